// ===== hdl/rpv_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types
// for the radial profile velocity block. No dependencies.
package rpv_pkg;

   // Profile table
   localparam int TABLE_DEPTH = 64;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);

   // Register indexes on the csr port
   localparam logic [1:0] REG_CENTER = 2'd0;
   localparam logic [1:0] REG_SCALE  = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   // Register reset values
   localparam logic [22:0] CENTER_RST = 23'd6442451;
   localparam logic [31:0] SCALE_RST  = 32'd65536;
   localparam logic [6:0]  COUNT_RST  = 7'd0;

   // Iterative units: one root bit / one quotient bit per cycle
   localparam int SQRT_STEPS = 24;
   localparam int DIV_STEPS  = 24;
   localparam int STEP_W     = $clog2(SQRT_STEPS);

   // 1.0 in Q4.28 (r^2 scale)
   localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

   // Output saturation
   localparam logic [23:0] OUT_MAX = 24'h7F_FFFF;

   typedef struct packed {
      logic capture;    // latch point coordinates
      logic load;       // write one table entry
      logic square;     // r^2 and root unit start
      logic parab;      // analytic parabola
      logic sqrt_step;  // one root bit
      logic rd_last;    // read the last entry in use
      logic zero_u;     // point at or past last radius
      logic scan_init;  // restart neighbour scan
      logic scan_rd;    // read next entry of scan
      logic scan_cmp;   // compare entry read last cycle
      logic mul;        // slope numerator product, divider start
      logic div_step;   // one quotient bit
      logic finish;     // add interpolated step, clamp
      logic scale;      // apply velocity_scale
      logic out_load;   // saturate into output register
   } rpv_cmd_type;

   typedef struct packed {
      logic empty;      // table_count is zero
      logic above;      // entry read has radius above r
      logic first;      // scan is still at entry 0
   } rpv_stat_type;

endpackage

// ===== hdl/rpv_dpath.sv =====
// Datapath: config registers, profile memory, root and divide units,
// interpolation and output scaling. Depends on rpv_pkg.
module rpv_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic [5:0]            entry_index,
   input  logic signed [15:0]    entry_radius,
   input  logic signed [23:0]    entry_velocity,
   input  logic signed [15:0]    coord_y,
   input  logic signed [15:0]    coord_z,
   input  rpv_pkg::rpv_cmd_type  cmd,
   output rpv_pkg::rpv_stat_type stat,
   output logic [23:0]           rsp_data
);

   // config
   logic [22:0] center_ff;
   logic [31:0] scale_ff;
   logic [6:0]  count_ff;

   // table: {abs radius, velocity}
   logic [39:0] tbl_mem [rpv_pkg::TABLE_DEPTH];
   logic [39:0] tbl_rd_ff;
   logic [39:0] prev_ff;
   logic [rpv_pkg::TBL_AW-1:0] scan_ff;
   logic [rpv_pkg::TBL_AW-1:0] rd_addr;
   logic [rpv_pkg::TBL_AW-1:0] last_addr;
   logic        first_ff;
   logic        wr_ok;
   logic [15:0] rad_abs;

   // point
   logic signed [15:0] y_ff;
   logic signed [15:0] z_ff;
   logic signed [31:0] sq_y;
   logic signed [31:0] sq_z;
   logic [31:0] r2_in;
   logic [31:0] r2_ff;

   // root unit
   logic [47:0] shv_ff;
   logic [25:0] srem_ff;
   logic [23:0] root_ff;
   logic [27:0] s_nxt;
   logic [27:0] s_trial;

   // parabola
   logic [28:0] par_diff;
   logic [51:0] par_prod;

   // interpolation
   logic [15:0]        ent_r;
   logic signed [23:0] ent_u;
   logic [23:0]        ent_rs;
   logic [15:0]        prev_r;
   logic signed [23:0] prev_u;
   logic signed [24:0] du;
   logic [23:0] num_ff;
   logic [23:0] den_ff;
   logic [23:0] dmag_ff;
   logic        dneg_ff;
   logic signed [23:0] ulo_ff;
   logic [47:0] div_prod;
   logic [23:0] drem_ff;
   logic [23:0] dlow_ff;
   logic [24:0] d_t;
   logic        d_ge;
   logic signed [25:0] q_s;
   logic signed [25:0] fin_sum;

   // result
   logic [22:0] u_ff;
   logic [54:0] p_ff;
   logic [23:0] rsp_ff;

   // ---- config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= rpv_pkg::CENTER_RST;
         scale_ff  <= rpv_pkg::SCALE_RST;
         count_ff  <= rpv_pkg::COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rpv_pkg::REG_CENTER: center_ff <= csr_wdata[22:0];
            rpv_pkg::REG_SCALE:  scale_ff  <= csr_wdata;
            rpv_pkg::REG_COUNT:  count_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // ---- profile memory
   assign rad_abs = entry_radius[15] ? 16'(-entry_radius) : entry_radius;
   assign wr_ok   = ({26'd0, entry_index} < 32'(rpv_pkg::TABLE_DEPTH));

   // count above depth acts as depth
   assign last_addr = ({25'd0, count_ff} >= 32'(rpv_pkg::TABLE_DEPTH)) ?
                      rpv_pkg::TBL_AW'(rpv_pkg::TABLE_DEPTH - 1) :
                      rpv_pkg::TBL_AW'(count_ff - 7'd1);
   assign rd_addr   = cmd.rd_last ? last_addr : scan_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         tbl_mem[rpv_pkg::TBL_AW'(entry_index)] <= {rad_abs, entry_velocity};
      end
      tbl_rd_ff <= tbl_mem[rd_addr];
   end

   assign ent_r  = tbl_rd_ff[39:24];
   assign ent_u  = tbl_rd_ff[23:0];
   assign ent_rs = {ent_r, 8'd0};
   assign prev_r = prev_ff[39:24];
   assign prev_u = prev_ff[23:0];

   // ---- point and r^2
   assign sq_y  = 32'(y_ff) * 32'(y_ff);
   assign sq_z  = 32'(z_ff) * 32'(z_ff);
   assign r2_in = 32'($unsigned(sq_y)) + 32'($unsigned(sq_z));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         y_ff <= coord_y;
         z_ff <= coord_z;
      end
      if (cmd.square) begin
         r2_ff <= r2_in;
      end
   end

   // ---- root unit, restoring, two radicand bits per step
   assign s_nxt   = {srem_ff, shv_ff[47:46]};
   assign s_trial = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         shv_ff  <= {r2_in, 16'd0};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         shv_ff <= {shv_ff[45:0], 2'b00};
         if (s_nxt >= s_trial) begin
            srem_ff <= 26'(s_nxt - s_trial);
            root_ff <= {root_ff[22:0], 1'b1};
         end else begin
            srem_ff <= s_nxt[25:0];
            root_ff <= {root_ff[22:0], 1'b0};
         end
      end
   end

   // ---- parabola
   assign par_diff = 29'(rpv_pkg::ONE_Q28) - 29'(r2_ff);
   assign par_prod = 52'(center_ff) * 52'(par_diff);

   // ---- neighbour scan
   assign du = 25'(ent_u) - 25'(prev_u);

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.scan_rd) begin
            scan_ff <= scan_ff + rpv_pkg::TBL_AW'(1);
         end
         if (cmd.scan_cmp && !stat.above) begin
            prev_ff  <= tbl_rd_ff;
            first_ff <= 1'b0;
         end
      end
      if (cmd.scan_cmp && stat.above && !first_ff) begin
         num_ff  <= root_ff - {prev_r, 8'd0};
         den_ff  <= {16'(ent_r - prev_r), 8'd0};
         dneg_ff <= du[24];
         dmag_ff <= du[24] ? 24'(-du) : du[23:0];
         ulo_ff  <= prev_u;
      end
   end

   // ---- divider, restoring, one quotient bit per step
   assign div_prod = 48'(dmag_ff) * 48'(num_ff);
   assign d_t      = {drem_ff, dlow_ff[23]};
   assign d_ge     = (d_t >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         drem_ff <= div_prod[47:24];
         dlow_ff <= div_prod[23:0];
      end else if (cmd.div_step) begin
         drem_ff <= d_ge ? 24'(d_t - {1'b0, den_ff}) : d_t[23:0];
         dlow_ff <= {dlow_ff[22:0], d_ge};
      end
   end

   // quotient truncated toward zero, sign of du applied after
   assign q_s     = dneg_ff ? -$signed({2'b00, dlow_ff}) : $signed({2'b00, dlow_ff});
   assign fin_sum = 26'(ulo_ff) + q_s;

   // ---- physical velocity, clamped at zero
   always_ff @(posedge clock) begin
      priority if (cmd.parab) begin
         u_ff <= (r2_ff < rpv_pkg::ONE_Q28) ? par_prod[50:28] : '0;
      end else if (cmd.zero_u) begin
         u_ff <= '0;
      end else if (cmd.scan_cmp && stat.above && first_ff) begin
         u_ff <= ent_u[23] ? '0 : ent_u[22:0];
      end else if (cmd.finish) begin
         u_ff <= fin_sum[25] ? '0 : fin_sum[22:0];
      end else begin
         u_ff <= u_ff;
      end
   end

   // ---- scaling and saturation
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         p_ff <= 55'(u_ff) * 55'(scale_ff);
      end
      if (cmd.out_load) begin
         rsp_ff <= (|p_ff[54:48]) ? rpv_pkg::OUT_MAX : {1'b0, p_ff[47:25]};
      end
   end

   assign rsp_data   = rsp_ff;
   assign stat.empty = (count_ff == 7'd0);
   assign stat.above = (ent_rs > root_ff);
   assign stat.first = first_ff;

endmodule

// ===== hdl/rpv_ctrl.sv =====
// Controller: sequences one item at a time through the datapath and owns
// the handshake flags. Depends on rpv_pkg.
module rpv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rpv_pkg::rpv_stat_type stat,
   output rpv_pkg::rpv_cmd_type  cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_SQUARE   = 12'b0000_0000_0010,
      ST_PARAB    = 12'b0000_0000_0100,
      ST_SQRT     = 12'b0000_0000_1000,
      ST_LAST_RD  = 12'b0000_0001_0000,
      ST_LAST_CHK = 12'b0000_0010_0000,
      ST_SCAN     = 12'b0000_0100_0000,
      ST_MUL      = 12'b0000_1000_0000,
      ST_DIV      = 12'b0001_0000_0000,
      ST_FINISH   = 12'b0010_0000_0000,
      ST_SCALE    = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [rpv_pkg::STEP_W-1:0]  iter_ff, iter_in;
   logic                        pend_ff, pend_in;
   logic                        rsp_valid_ff;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      pend_in    = pend_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SQUARE;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            iter_in    = '0;
            state_in   = stat.empty ? ST_PARAB : ST_SQRT;
         end
         ST_PARAB: begin
            cmd.parab = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + rpv_pkg::STEP_W'(1);
            if (iter_ff == rpv_pkg::STEP_W'(rpv_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_LAST_RD;
            end
         end
         ST_LAST_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = ST_LAST_CHK;
         end
         ST_LAST_CHK: begin
            pend_in = 1'b0;
            if (stat.above) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.zero_u = 1'b1;
               state_in   = ST_SCALE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            pend_in     = 1'b1;
            if (pend_ff) begin
               cmd.scan_cmp = 1'b1;
               if (stat.above) begin
                  state_in = stat.first ? ST_SCALE : ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + rpv_pkg::STEP_W'(1);
            if (iter_ff == rpv_pkg::STEP_W'(rpv_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         pend_ff  <= pend_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // output register never overwritten while a result waits
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while full");

   // a result appears only from the final state
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result valid raised outside DONE");

   // iteration counter stays inside the unit's step count
   a_iter_rng: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT || state_ff == ST_DIV) |->
      (iter_ff <= rpv_pkg::STEP_W'(rpv_pkg::SQRT_STEPS - 1)))
      else $error("iteration counter out of range");

   // an evaluate transfer always starts the square stage
   a_eval_go: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (state_ff == ST_SQUARE))
      else $error("evaluate transfer did not start");

endmodule

// ===== hdl/radial_profile_velocity.sv =====
// Top level of the radial profile velocity block: port unpacking and the
// controller/datapath pair. Depends on rpv_pkg, rpv_ctrl, rpv_dpath.
//
//  - req: tuser=0 loads one profile entry (absolute radius, velocity) into
//    slot entry_index, no result. tuser=1 evaluates a point and gives one
//    rsp transfer with the saturated Q1.22 velocity.
//  - csr: plain write; 0 centre velocity, 1 velocity scale, 2 table count
//    (0 = analytic parabola). Write only while idle.
//  - One item at a time; req_tready is high only while the controller idles.
//  - Evaluate: square, then the parabola if the table count is zero; else the
//    24-step root unit, a read of the last entry (zero at or past its radius),
//    the entry-per-cycle scan over the single memory read port (first entry's
//    velocity before the first radius) and the 24-step divider; then scaling.
//    The next item is taken the cycle after the result is registered.
//  - A waiting result does not block the next item; only the result stage
//    stalls until the waiting transfer completes.
//  - Reset (synchronous, active high) returns to idle, drops rsp_tvalid and
//    restores register defaults; the profile memory is not cleared.
module radial_profile_velocity (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: entry_index[5:0], entry_radius[21:6], entry_velocity[45:22],
   //        coord_y[61:46], coord_z[77:62], zero fill [79:78]
   input  logic [79:0] req_tdata,
   // tuser: kind (0 load, 1 evaluate)
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: lattice_velocity[23:0]
   output logic [23:0] rsp_tdata,
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   rpv_pkg::rpv_cmd_type  cmd;
   rpv_pkg::rpv_stat_type stat;

   logic [5:0]         entry_index;
   logic signed [15:0] entry_radius;
   logic signed [23:0] entry_velocity;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;

   assign entry_index    = req_tdata[5:0];
   assign entry_radius   = req_tdata[21:6];
   assign entry_velocity = req_tdata[45:22];
   assign coord_y        = req_tdata[61:46];
   assign coord_z        = req_tdata[77:62];

   // sequencer: one item in flight, result handshake
   rpv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic, profile memory and config registers
   rpv_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .entry_index    (entry_index),
      .entry_radius   (entry_radius),
      .entry_velocity (entry_velocity),
      .coord_y        (coord_y),
      .coord_z        (coord_z),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_data       (rsp_tdata)
   );

endmodule
